>>> src/tmrb_pkg.sv
package tmrb_pkg;

  localparam int unsigned RowStep   = 16;
  localparam int unsigned ClipAlign = 16;

  typedef enum logic [1:0] {
    DIV_COL,
    DIV_ROW,
    DIV_TRY,
    DIV_BUD
  } div_src_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_GO,
    ST_COL_WAIT,
    ST_ROW_GO,
    ST_ROW_WAIT,
    ST_MUL,
    ST_BUD_GO,
    ST_BUD_WAIT,
    ST_BUDGET,
    ST_CHECK,
    ST_TRY_GO,
    ST_TRY_WAIT,
    ST_TRY_MUL,
    ST_COMPARE,
    ST_CLIP
  } state_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_e div_src;
    logic     col_cap;
    logic     mul;
    logic     budget;
    logic     step;
    logic     clip;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic can_shrink;
    logic fits;
  } status_t;

endpackage

>>> src/tmrb_div.sv
module tmrb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        wide_i,
  input  logic [63:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [15:0] rem_o
);

  logic [63:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {rem_q, dq_q[63]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d  = wide_i ? dividend_i : {dividend_i[31:0], 32'b0};
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = wide_i ? 7'd64 : 7'd32;
      run_d = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = diff[15:0];
        dq_d  = {dq_q[62:0], 1'b1};
      end else begin
        rem_d = shifted[15:0];
        dq_d  = {dq_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

>>> src/tmrb_dp.sv
module tmrb_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic [31:0]       rows_total_i,
  input  logic [31:0]       cols_total_i,
  input  logic [15:0]       tile_rows_in_i,
  input  logic [15:0]       tile_cols_in_i,
  input  logic [15:0]       row_floor_i,
  input  tmrb_pkg::ctrl_t   ctrl_i,
  output tmrb_pkg::status_t status_o,
  output logic              done_o,
  output logic [16:0]       tile_rows_out_o,
  output logic [16:0]       tile_cols_out_o
);

  logic [15:0] cores_q;
  logic [15:0] cores_eff;
  logic [31:0] rows_q, cols_q;
  logic [15:0] trow_q, tcol_q, floor_q;
  logic [31:0] col_tiles_q;
  logic [63:0] prod_q, budget_q;
  logic [16:0] trow_out_q, tcol_out_q;
  logic        done_q;

  logic        div_wide;
  logic [63:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quot;
  logic [15:0] div_rem;
  logic [31:0] ceil_w;
  logic [63:0] prod_w;
  logic [15:0] adj_w;
  logic [15:0] trow_try;
  logic [16:0] rows_rnd, cols_rnd;

  assign cores_eff = (cores_q == 16'd0) ? 16'd1 : cores_q;
  assign trow_try  = trow_q - 16'(tmrb_pkg::RowStep);

  always_comb begin
    div_wide     = 1'b0;
    div_dividend = {32'b0, cols_q};
    div_divisor  = tcol_q;
    case (ctrl_i.div_src)
      tmrb_pkg::DIV_COL: begin
        div_dividend = {32'b0, cols_q};
        div_divisor  = tcol_q;
      end
      tmrb_pkg::DIV_ROW: begin
        div_dividend = {32'b0, rows_q};
        div_divisor  = trow_q;
      end
      tmrb_pkg::DIV_TRY: begin
        div_dividend = {32'b0, rows_q};
        div_divisor  = trow_try;
      end
      tmrb_pkg::DIV_BUD: begin
        div_wide     = 1'b1;
        div_dividend = prod_q;
        div_divisor  = cores_eff;
      end
      default: begin
        div_dividend = {32'b0, cols_q};
        div_divisor  = tcol_q;
      end
    endcase
  end

  tmrb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .wide_i     (div_wide),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign ceil_w = div_quot[31:0] + {31'b0, (div_rem != 16'd0)};
  assign prod_w = 64'(ceil_w) * 64'(col_tiles_q);
  assign adj_w  = (div_rem == 16'd0) ? 16'd0 : cores_eff - div_rem;

  // round up to the clip alignment, only used when the size is below the tile
  assign rows_rnd = ({1'b0, rows_q[15:0]} + 17'(tmrb_pkg::ClipAlign - 1))
                    & ~17'(tmrb_pkg::ClipAlign - 1);
  assign cols_rnd = ({1'b0, cols_q[15:0]} + 17'(tmrb_pkg::ClipAlign - 1))
                    & ~17'(tmrb_pkg::ClipAlign - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cores_q <= 16'd1;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cores_q <= cfg_wdata_i;
      end
      done_q <= ctrl_i.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rows_q  <= rows_total_i;
      cols_q  <= cols_total_i;
      trow_q  <= (tile_rows_in_i == 16'd0) ? 16'd1 : tile_rows_in_i;
      tcol_q  <= (tile_cols_in_i == 16'd0) ? 16'd1 : tile_cols_in_i;
      floor_q <= row_floor_i;
    end else if (ctrl_i.step) begin
      trow_q <= trow_try;
    end
    if (ctrl_i.col_cap) begin
      col_tiles_q <= ceil_w;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_w;
    end
    if (ctrl_i.budget) begin
      budget_q <= prod_q + {48'b0, adj_w};
    end
    if (ctrl_i.clip) begin
      trow_out_q <= (rows_q < {16'b0, trow_q}) ? rows_rnd : {1'b0, trow_q};
      tcol_out_q <= (cols_q < {16'b0, tcol_q}) ? cols_rnd : {1'b0, tcol_q};
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.can_shrink = (trow_q > floor_q) && (trow_q > 16'(tmrb_pkg::RowStep));
  assign status_o.fits       = (prod_q <= budget_q);

  assign done_o          = done_q;
  assign tile_rows_out_o = trow_out_q;
  assign tile_cols_out_o = tcol_out_q;

endmodule

>>> src/tmrb_ctrl.sv
module tmrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  tmrb_pkg::status_t status_i,
  output tmrb_pkg::ctrl_t   ctrl_o,
  output logic              busy
);

  tmrb_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tmrb_pkg::ST_IDLE:     if (start) state_d = tmrb_pkg::ST_COL_GO;
      tmrb_pkg::ST_COL_GO:   state_d = tmrb_pkg::ST_COL_WAIT;
      tmrb_pkg::ST_COL_WAIT: if (status_i.div_done) state_d = tmrb_pkg::ST_ROW_GO;
      tmrb_pkg::ST_ROW_GO:   state_d = tmrb_pkg::ST_ROW_WAIT;
      tmrb_pkg::ST_ROW_WAIT: if (status_i.div_done) state_d = tmrb_pkg::ST_MUL;
      tmrb_pkg::ST_MUL:      state_d = tmrb_pkg::ST_BUD_GO;
      tmrb_pkg::ST_BUD_GO:   state_d = tmrb_pkg::ST_BUD_WAIT;
      tmrb_pkg::ST_BUD_WAIT: if (status_i.div_done) state_d = tmrb_pkg::ST_BUDGET;
      tmrb_pkg::ST_BUDGET:   state_d = tmrb_pkg::ST_CHECK;
      tmrb_pkg::ST_CHECK: begin
        state_d = status_i.can_shrink ? tmrb_pkg::ST_TRY_GO : tmrb_pkg::ST_CLIP;
      end
      tmrb_pkg::ST_TRY_GO:   state_d = tmrb_pkg::ST_TRY_WAIT;
      tmrb_pkg::ST_TRY_WAIT: if (status_i.div_done) state_d = tmrb_pkg::ST_TRY_MUL;
      tmrb_pkg::ST_TRY_MUL:  state_d = tmrb_pkg::ST_COMPARE;
      tmrb_pkg::ST_COMPARE: begin
        state_d = status_i.fits ? tmrb_pkg::ST_CHECK : tmrb_pkg::ST_CLIP;
      end
      tmrb_pkg::ST_CLIP:     state_d = tmrb_pkg::ST_IDLE;
      default:               state_d = tmrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o         = '0;
    ctrl_o.div_src = tmrb_pkg::DIV_COL;
    case (state_q)
      tmrb_pkg::ST_IDLE:     ctrl_o.load = start;
      tmrb_pkg::ST_COL_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = tmrb_pkg::DIV_COL;
      end
      tmrb_pkg::ST_COL_WAIT: ctrl_o.col_cap = status_i.div_done;
      tmrb_pkg::ST_ROW_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = tmrb_pkg::DIV_ROW;
      end
      tmrb_pkg::ST_MUL:      ctrl_o.mul = 1'b1;
      tmrb_pkg::ST_BUD_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = tmrb_pkg::DIV_BUD;
      end
      tmrb_pkg::ST_BUD_WAIT: ctrl_o.div_src = tmrb_pkg::DIV_BUD;
      tmrb_pkg::ST_BUDGET: begin
        ctrl_o.budget  = 1'b1;
        ctrl_o.div_src = tmrb_pkg::DIV_BUD;
      end
      tmrb_pkg::ST_TRY_GO: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_src   = tmrb_pkg::DIV_TRY;
      end
      tmrb_pkg::ST_TRY_MUL:  ctrl_o.mul = 1'b1;
      tmrb_pkg::ST_COMPARE:  ctrl_o.step = status_i.fits;
      tmrb_pkg::ST_CLIP:     ctrl_o.clip = 1'b1;
      default:               ctrl_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tmrb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != tmrb_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_step_only_in_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.step |=> state_q == tmrb_pkg::ST_CHECK)
    else $error("row step without return to check");

  a_clip_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tmrb_pkg::ST_CLIP |=> state_q == tmrb_pkg::ST_IDLE)
    else $error("clip not followed by idle");

  a_budget_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tmrb_pkg::ST_BUDGET |-> $past(status_i.div_done))
    else $error("budget taken before divider finished");
`endif

endmodule

>>> src/matmul_tile_row_balancer_core.sv
// the result beat follows the column, row and budget divisions, plus a trial division for
//   each row step taken and for a final attempt that does not fit
// the shared divider is radix-2, 32 steps for 32-bit sizes and 64 for the budget
// one item in flight; start is taken only while busy is low, again in the result cycle
// done_o pulses one cycle with the result, and the receiver cannot stall it
// async active-low reset returns to idle and sets core_count to 1
module matmul_tile_row_balancer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] rows_total_i,
  input  logic [31:0] cols_total_i,
  input  logic [15:0] tile_rows_in_i,
  input  logic [15:0] tile_cols_in_i,
  input  logic [15:0] row_floor_i,
  output logic        done_o,
  output logic [16:0] tile_rows_out_o,
  output logic [16:0] tile_cols_out_o
);

  tmrb_pkg::ctrl_t   ctrl;
  tmrb_pkg::status_t status;

  tmrb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  tmrb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rows_total_i    (rows_total_i),
    .cols_total_i    (cols_total_i),
    .tile_rows_in_i  (tile_rows_in_i),
    .tile_cols_in_i  (tile_cols_in_i),
    .row_floor_i     (row_floor_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .done_o          (done_o),
    .tile_rows_out_o (tile_rows_out_o),
    .tile_cols_out_o (tile_cols_out_o)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without work");
`endif

endmodule
